FILE: design/pgalloc_pkg.sv
package pgalloc_pkg;

  localparam int PAGE_COUNT = 32768;
  localparam int PAGE_SHIFT = 12;

  localparam int ADDR_W  = 40;
  localparam int CNT_W   = 16;
  localparam int MODE_W  = 3;
  localparam int STAT_W  = 2;
  localparam int CFG_W   = 2;
  localparam int IDX_W   = $clog2(PAGE_COUNT);
  localparam int DEP_W   = $clog2(PAGE_COUNT + 1);
  localparam int PG_W    = ADDR_W - PAGE_SHIFT;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_ALLOC  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FREE   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FIND   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ADD    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd4;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FAULT    = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_W-1:0] CFG_MEM_BASE   = 2'd0;
  localparam logic [CFG_W-1:0] CFG_FREE_FLOOR = 2'd1;
  localparam logic [CFG_W-1:0] CFG_MEM_TOP    = 2'd2;

  localparam logic [ADDR_W-1:0] MEM_BASE_RST   = 40'h00_8000_0000;
  localparam logic [ADDR_W-1:0] FREE_FLOOR_RST = 40'h00_8000_0000;
  localparam logic [ADDR_W-1:0] MEM_TOP_RST    = 40'h00_8800_0000;

  localparam logic signed [CNT_W-1:0] CNT_MAX = 16'sh7fff;
  localparam logic signed [CNT_W-1:0] CNT_MIN = -16'sh8000;
  localparam logic signed [CNT_W-1:0] CNT_ONE = 16'sh0001;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] page_address;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic [ADDR_W-1:0]        result_address;
    logic signed [CNT_W-1:0]  old_count;
  } out_item_t;

  // Address check results
  typedef struct packed {
    logic             free_ok;
    logic             idx_ok;
    logic [IDX_W-1:0] idx;
  } chk_t;

endpackage

FILE: design/pgalloc_ram.sv
module pgalloc_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/pgalloc_chk.sv
module pgalloc_chk
  import pgalloc_pkg::*;
(
  input  logic [ADDR_W-1:0] addr,
  input  logic [ADDR_W-1:0] mem_base,
  input  logic [ADDR_W-1:0] free_floor,
  input  logic [ADDR_W-1:0] mem_top,
  output chk_t              chk
);

  logic [ADDR_W-1:0] off;
  logic [PG_W-1:0]   pg;
  logic              aligned;

  always_comb begin
    off     = addr - mem_base;   // wraps for addresses below the base
    pg      = off[ADDR_W-1:PAGE_SHIFT];
    aligned = (addr[PAGE_SHIFT-1:0] == '0);
    chk.idx_ok  = (pg < PG_W'(PAGE_COUNT));
    chk.idx     = pg[IDX_W-1:0];
    chk.free_ok = aligned && (addr >= free_floor) && (addr < mem_top) && chk.idx_ok;
  end

endmodule

FILE: design/page_allocator_with_refcounts.sv
// Page allocator with per-page reference counts.
// Input channel in_valid/in_ready carries an item {mode, page_address}; result
// channel out_valid/out_ready returns one item {status, result_address,
// old_count} for every input item, in order.
// Config: cfg_we with cfg_index/cfg_data writes mem_base, free_floor or mem_top;
// write only while the block is idle.
// Each item passes through IDLE, where the accept cycle issues the read of
// the count memory (and of the free stack for alloc), and EXEC, which
// modifies, writes back and loads the output register. The single read/write
// port pair of the count memory sets this; a new item is taken only after the
// last one has left EXEC. out_valid is registered and rises as the item leaves
// EXEC. A new item is taken while an earlier result waits in the output
// register; if that result is still not taken when the next one is ready, the
// block holds that item in EXEC and stops accepting until out_ready rises.
// Reset (rst_n low, synchronous) empties the free stack, restores the config
// defaults and starts a clearing pass over all PAGE_COUNT (32768) entries of
// the count memory; in_ready stays low until it completes. Config writes are
// taken throughout.
module page_allocator_with_refcounts
  import pgalloc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_item,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_index,
  input  logic [ADDR_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  clr_r, clr_nxt;
  logic [DEP_W-1:0]  depth_r, depth_nxt;
  logic [ADDR_W-1:0] mem_base_r, free_floor_r, mem_top_r;
  logic [MODE_W-1:0] mode_r;
  chk_t              chk_r;
  chk_t              chk;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  logic              accept;
  logic              exec_go;
  logic [DEP_W-1:0]  depth_m1;

  logic              cnt_we;
  logic [IDX_W-1:0]  cnt_waddr;
  logic [CNT_W-1:0]  cnt_wdata;
  logic [CNT_W-1:0]  cnt_rdata;
  logic signed [CNT_W-1:0] cnt_old;

  logic              stk_we;
  logic              stk_re;
  logic [IDX_W-1:0]  stk_rdata;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign exec_go   = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign depth_m1  = depth_r - DEP_W'(1);
  assign stk_re    = accept && (in_item.mode == MODE_ALLOC) && (depth_r != '0);
  assign cnt_old   = cnt_rdata;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  pgalloc_chk u_chk (
    .addr       (in_item.page_address),
    .mem_base   (mem_base_r),
    .free_floor (free_floor_r),
    .mem_top    (mem_top_r),
    .chk        (chk)
  );

  pgalloc_ram #(.DEPTH(PAGE_COUNT), .WIDTH(CNT_W)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (accept),
    .raddr (chk.idx),
    .rdata (cnt_rdata)
  );

  pgalloc_ram #(.DEPTH(PAGE_COUNT), .WIDTH(IDX_W)) u_stk_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (depth_r[IDX_W-1:0]),
    .wdata (chk_r.idx),
    .re    (stk_re),
    .raddr (depth_m1[IDX_W-1:0]),
    .rdata (stk_rdata)
  );

  // Clear pass writes zeros; execute: memory read data is valid, modify and write back
  always_comb begin
    cnt_we       = 1'b0;
    cnt_waddr    = chk_r.idx;
    cnt_wdata    = '0;
    stk_we       = 1'b0;
    depth_nxt    = depth_r;
    out_item_nxt = '{status: ST_OK, result_address: '0, old_count: '0};

    if (state_r == S_CLEAR) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_r;
    end else if (exec_go) begin
      priority if (mode_r == MODE_ALLOC) begin
        if (depth_r == '0) begin
          out_item_nxt.status = ST_EMPTY;
        end else begin
          cnt_we    = 1'b1;
          cnt_waddr = stk_rdata;
          cnt_wdata = CNT_ONE;
          depth_nxt = depth_m1;
          out_item_nxt.result_address =
            mem_base_r + (ADDR_W'(stk_rdata) << PAGE_SHIFT);
        end
      end else if (mode_r == MODE_FREE) begin
        if (!chk_r.free_ok) begin
          out_item_nxt.status = ST_FAULT;
        end else if (cnt_old > CNT_ONE) begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_old - CNT_ONE;
        end else begin
          cnt_we = 1'b1;
          if (depth_r == DEP_W'(PAGE_COUNT)) begin
            out_item_nxt.status = ST_OVERFLOW;
          end else begin
            stk_we    = 1'b1;
            depth_nxt = depth_r + DEP_W'(1);
          end
        end
      end else if (mode_r == MODE_FIND || mode_r == MODE_ADD || mode_r == MODE_REMOVE) begin
        if (!chk_r.idx_ok) begin
          out_item_nxt.status = ST_FAULT;
        end else begin
          out_item_nxt.old_count = cnt_old;
          if (mode_r == MODE_ADD && cnt_old != CNT_MAX) begin
            cnt_we    = 1'b1;
            cnt_wdata = cnt_old + CNT_ONE;
          end else if (mode_r == MODE_REMOVE && cnt_old != CNT_MIN) begin
            cnt_we    = 1'b1;
            cnt_wdata = cnt_old - CNT_ONE;
          end
        end
      end else begin
        out_item_nxt.status = ST_OK;  // unused modes: nothing changes
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + IDX_W'(1);
        if (clr_r == IDX_W'(PAGE_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase

    if (exec_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_base_r   <= MEM_BASE_RST;
      free_floor_r <= FREE_FLOOR_RST;
      mem_top_r    <= MEM_TOP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MEM_BASE:   mem_base_r   <= cfg_data;
        CFG_FREE_FLOOR: free_floor_r <= cfg_data;
        CFG_MEM_TOP:    mem_top_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // item context and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_item.mode;
      chk_r  <= chk;
    end
    if (exec_go) begin
      out_item_r <= out_item_nxt;
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_EXEC)
    else $error("accepted item did not move to execute");

  a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEP_W'(PAGE_COUNT))
    else $error("free stack depth beyond page count");

  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    exec_go |=> out_valid_r && state_r == S_IDLE)
    else $error("executed item gave no result");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    stk_re |-> depth_r != '0 && !stk_we)
    else $error("pop from empty free stack");

endmodule
